// File: rtl/cdq_pkg.sv
// Package for the circular deque unit: widths, operation codes and the
// status record that travels down the result pipeline. No dependencies.
`default_nettype none

package cdq_pkg;

   localparam int WORD_W        = 32;
   localparam int CNT_W         = 5;
   localparam int OP_W          = 3;
   localparam int DEPTH_DEFAULT = 16;

   // Operation codes carried in the op field of a request beat.
   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_PEEK       = 3'd4
   } op_type;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic        [CNT_W-1:0]  cnt_type;

   // Status of one operation, carried from the state update to the result register.
   typedef struct packed {
      logic    ok;
      logic    is_empty;
      logic    is_full;
      cnt_type count;
   } status_type;

endpackage

`default_nettype wire

// File: rtl/cdq_ifs.sv
// Valid/ready channel interfaces for request and response beats of the
// circular deque unit. Depends on cdq_pkg.
`default_nettype none

interface cdq_req_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   op_type   op;
   word_type value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   logic     ok;
   word_type front_value;
   word_type rear_value;
   logic     is_empty;
   logic     is_full;
   cnt_type  count;

   modport source (output valid, output ok, output front_value, output rear_value,
                   output is_empty, output is_full, output count, input ready);
   modport sink   (input valid, input ok, input front_value, input rear_value,
                   input is_empty, input is_full, input count, output ready);
endinterface

`default_nettype wire

// File: rtl/circular_deque_unit.sv
// Top level of the circular deque unit: ring-buffer double-ended queue with
// a capacity register. Depends on cdq_pkg and the channel interfaces in cdq_ifs.
//
// Usage. Each request beat on req_chan carries one operation (push front, push
// back, pop front, pop back or peek) and a signed word used by pushes. Every
// request beat produces exactly one response beat on rsp_chan, in order, with
// the ok flag, the front and rear words after the operation (all ones when the
// deque is empty), the empty and full flags and the entry count.
// Pipeline: a request beat, once accepted, updates the pointers, the count and
// the entry store and launches two registered reads of the store into the read
// stage (new front, new rear, with bypass of the word written at the same
// edge); the read stage then loads the response register, from which the
// response beat is taken.
// Throughput: one beat per cycle while the receiver keeps rsp_chan.ready high. The
// pointer update for the next request uses the state written at the previous edge,
// and the two read ports of the store are the only path to the stored words.
// Stalls: when the receiver holds rsp_chan.ready low, the response register
// and then the read stage hold their beats; req_chan.ready drops only once both
// are full, so one new request is still taken while a finished response waits.
// Reset: synchronous, active high. It empties the deque, drops both pipeline
// stages and sets the capacity to its largest value. The store itself is not
// cleared; only written entries reach a response. The capacity register is written
// through csr_wr_en/csr_wr_data only while the unit is idle, a rule for the user that
// the block does not enforce; a write saturates into 1..min(DEPTH,31), empties the deque.
`default_nettype none

module circular_deque_unit #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  wire                      clock,
   input  wire                      reset,
   cdq_req_if.sink                  req_chan,
   cdq_rsp_if.source                rsp_chan,
   input  wire                      csr_wr_en,
   input  wire [cdq_pkg::CNT_W-1:0] csr_wr_data
);
   import cdq_pkg::*;

   localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PW      = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
   localparam int CNT_MAX = (1 << CNT_W) - 1;
   // The capacity cannot exceed the store size nor what the count field can show.
   localparam int CAP_MAX_I = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;
   localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_MAX_I);

   typedef logic [IDX_W-1:0] idx_type;

   // ------------------------------------------------------------------
   // Architectural state.
   // ------------------------------------------------------------------
   word_type entry_store_ff [DEPTH];
   idx_type  head_ff, head_in;
   idx_type  tail_ff, tail_in;
   cnt_type  count_ff, count_in;
   cnt_type  cap_ff, cap_in;

   // Read stage and response register.
   logic       s1_valid_ff;
   status_type s1_stat_ff, s1_stat_in;
   word_type   front_rd_ff;
   word_type   rear_rd_ff;

   logic       out_valid_ff;
   status_type out_stat_ff;
   word_type   out_front_ff;
   word_type   out_rear_ff;

   // Handshake. The response register advances when it is empty or taken,
   // the read stage when it is empty or can move on.
   logic out_adv;
   logic s1_adv;
   logic accept;

   assign out_adv        = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_adv;
   assign req_chan.ready = !s1_valid_ff || out_adv;
   assign accept         = req_chan.valid && req_chan.ready;

   // ------------------------------------------------------------------
   // Operation decode and pointer update.
   // ------------------------------------------------------------------
   logic    is_empty_now;
   logic    is_full_now;
   logic    ok;
   logic    wr_en;
   idx_type wr_idx;
   idx_type cap_last;
   idx_type head_up;
   idx_type head_down;
   idx_type tail_up;
   idx_type tail_down;
   logic [PW-1:0] head_inc;
   logic [PW-1:0] tail_inc;

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff >= cap_ff);
   assign cap_last     = IDX_W'(cap_ff - CNT_W'(1));
   assign head_inc     = PW'(head_ff) + PW'(1);
   assign tail_inc     = PW'(tail_ff) + PW'(1);

   // Wraparound steps inside the capacity in use.
   assign head_up   = (head_inc >= PW'(cap_ff)) ? '0 : IDX_W'(head_inc);
   assign tail_up   = (tail_inc >= PW'(cap_ff)) ? '0 : IDX_W'(tail_inc);
   assign head_down = (head_ff == '0) ? cap_last : head_ff - IDX_W'(1);
   assign tail_down = (tail_ff == '0) ? cap_last : tail_ff - IDX_W'(1);

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      ok       = 1'b0;
      wr_en    = 1'b0;
      wr_idx   = head_ff;
      unique case (req_chan.op)
         OP_PUSH_FRONT: begin
            if (!is_full_now) begin
               ok = 1'b1;
               if (is_empty_now) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  head_in = head_down;
               end
               wr_en    = 1'b1;
               wr_idx   = head_in;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (!is_full_now) begin
               ok = 1'b1;
               if (is_empty_now) begin
                  head_in = '0;
                  tail_in = '0;
               end else begin
                  tail_in = tail_up;
               end
               wr_en    = 1'b1;
               wr_idx   = tail_in;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_POP_FRONT: begin
            if (!is_empty_now) begin
               ok = 1'b1;
               // Taking the last entry returns both pointers to the start.
               if (count_ff == CNT_W'(1)) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end else begin
                  head_in  = head_up;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         OP_POP_BACK: begin
            if (!is_empty_now) begin
               ok = 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  head_in  = '0;
                  tail_in  = '0;
                  count_in = '0;
               end else begin
                  tail_in  = tail_down;
                  count_in = count_ff - CNT_W'(1);
               end
            end
         end
         OP_PEEK: begin
            ok = 1'b1;
         end
         default: begin
            // Undefined codes change nothing and report failure.
            ok = 1'b0;
         end
      endcase
   end

   // Capacity write saturates into the legal range.
   always_comb begin
      if (csr_wr_data == '0) begin
         cap_in = CNT_W'(1);
      end else if (csr_wr_data > CAP_MAX) begin
         cap_in = CAP_MAX;
      end else begin
         cap_in = csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= CAP_MAX;
      end else if (csr_wr_en) begin
         // A capacity write empties the deque.
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         cap_ff   <= cap_in;
      end else if (accept) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // ------------------------------------------------------------------
   // Entry store: one write port, two registered read ports. A read of the
   // entry written at the same edge takes the incoming word.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept && wr_en) begin
         entry_store_ff[wr_idx] <= req_chan.value;
      end
   end

   always_comb begin
      s1_stat_in.ok       = ok;
      s1_stat_in.is_empty = (count_in == '0);
      s1_stat_in.is_full  = (count_in == cap_ff);
      s1_stat_in.count    = count_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         front_rd_ff <= (wr_en && (wr_idx == head_in)) ? req_chan.value
                                                       : entry_store_ff[head_in];
         rear_rd_ff  <= (wr_en && (wr_idx == tail_in)) ? req_chan.value
                                                       : entry_store_ff[tail_in];
         s1_stat_ff  <= s1_stat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // ------------------------------------------------------------------
   // Response register. An empty deque shows all ones in both value fields.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         out_stat_ff  <= s1_stat_ff;
         out_front_ff <= s1_stat_ff.is_empty ? '1 : front_rd_ff;
         out_rear_ff  <= s1_stat_ff.is_empty ? '1 : rear_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.ok          = out_stat_ff.ok;
   assign rsp_chan.front_value = out_front_ff;
   assign rsp_chan.rear_value  = out_rear_ff;
   assign rsp_chan.is_empty    = out_stat_ff.is_empty;
   assign rsp_chan.is_full     = out_stat_ff.is_full;
   assign rsp_chan.count       = out_stat_ff.count;

endmodule

`default_nettype wire
